[design/cdse_pkg.sv]
// ----------------------------------------------------------------------------
// cdse_pkg: shared definitions for the card deck shuffle engine
// Field widths, request codes, stride limits and the command record that the
// front part passes to the back part.
// ----------------------------------------------------------------------------
package cdse_pkg;

  // Default deck size.
  localparam int DECK_SIZE_DEF = 54;

  // Field widths.
  localparam int CARD_W   = 6;
  localparam int REQ_W    = 2;
  localparam int RAND_W   = 15;
  localparam int STRIDE_W = 4;

  // Legal stride range; values outside are clamped.
  localparam int STRIDE_MIN = 3;
  localparam int STRIDE_MAX = 8;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INIT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SWAP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STRIDE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

  // One classified command as it waits in the queue.
  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [RAND_W-1:0]   rand_value;
    logic                reverse;
    logic [STRIDE_W-1:0] stride;
  } cmd_t;

endpackage

[design/card_deck_shuffle_engine_top.sv]
// ----------------------------------------------------------------------------
// card_deck_shuffle_engine_top: card deck shuffle engine
// Keeps a deck of DECK_SIZE cards and permutes it on request: identity load,
// one random swap step, stride pass (copy then deal by residue class), and
// readout of the whole deck.
//
//   Channel  Direction  Handshake            Payload
//   in       to block   in_valid/in_ready    req_type, rand_value,
//                                            reverse_copy, stride
//   out      from block out_valid/out_ready  card_value, last_card
//
// A swap step runs the bit-serial remainder unit, then one read and two
// writes on the deck memory. A stride pass reads and writes each card once
// in each of the copy and deal sweeps. A readout issues one deck read per
// card, and the next one only after the registered deck read has reached
// the result register and that register is free or being emptied, so it
// waits while out_ready is low. A two-entry queue takes requests while the
// back part works. Reset is synchronous and restores the identity order at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module card_deck_shuffle_engine_top #(
  parameter int DECK_SIZE = cdse_pkg::DECK_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cdse_pkg::REQ_W-1:0]      req_type,
  input  logic [cdse_pkg::RAND_W-1:0]     rand_value,
  input  logic                            reverse_copy,
  input  logic [cdse_pkg::STRIDE_W-1:0]   stride,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cdse_pkg::CARD_W-1:0]     card_value,
  output logic                            last_card
);
  import cdse_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Front: accept and classify requests, queue commands.
  cdse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .rand_value   (rand_value),
    .reverse_copy (reverse_copy),
    .stride       (stride),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  // Back: execute commands against the deck.
  cdse_back #(
    .DECK_SIZE (DECK_SIZE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .card_value (card_value),
    .last_card  (last_card)
  );

endmodule

[design/cdse_ram.sv]
// ----------------------------------------------------------------------------
// cdse_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered. A read of an
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module cdse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/cdse_front.sv]
// ----------------------------------------------------------------------------
// cdse_front: request intake and command queue
// Accepts request transactions, clamps the stride into its legal range and
// holds up to two commands for the back part.
// ----------------------------------------------------------------------------
module cdse_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cdse_pkg::REQ_W-1:0]      req_type,
  input  logic [cdse_pkg::RAND_W-1:0]     rand_value,
  input  logic                            reverse_copy,
  input  logic [cdse_pkg::STRIDE_W-1:0]   stride,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output cdse_pkg::cmd_t                  cmd
);
  import cdse_pkg::*;

  cmd_t       slot [2];
  cmd_t       cmd_in;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // Classify the incoming request and clamp the stride.
  always_comb begin
    cmd_in.req        = req_type;
    cmd_in.rand_value = rand_value;
    cmd_in.reverse    = reverse_copy;
    if (stride < STRIDE_W'(STRIDE_MIN)) begin
      cmd_in.stride = STRIDE_W'(STRIDE_MIN);
    end else if (stride > STRIDE_W'(STRIDE_MAX)) begin
      cmd_in.stride = STRIDE_W'(STRIDE_MAX);
    end else begin
      cmd_in.stride = stride;
    end
  end

  // Queue handshakes.
  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rptr];
  assign push      = in_valid & in_ready;
  assign pop       = cmd_valid & cmd_ready;

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= cmd_in;
    end
  end

endmodule

[design/cdse_mod.sv]
// ----------------------------------------------------------------------------
// cdse_mod: iterative remainder unit
// Restoring division that brings in one dividend bit per cycle and keeps only
// the remainder. Done pulses in the cycle after the last bit, with rem valid.
// ----------------------------------------------------------------------------
module cdse_mod #(
  parameter int DIV_W = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cdse_pkg::RAND_W-1:0]   dividend,
  input  logic [DIV_W-1:0]              divisor,
  output logic                          done,
  output logic [DIV_W-1:0]              rem
);
  import cdse_pkg::*;

  localparam int CNT_W = $clog2(RAND_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAND_W-1:0] shreg;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    trial;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem, shreg[RAND_W-1]};

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RAND_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: compare and subtract once per bit.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, dvs}) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIV_W-1:0];
      end
    end
  end

endmodule

[design/cdse_back.sv]
// ----------------------------------------------------------------------------
// cdse_back: command execution
// Runs init, swap step, stride pass and readout against the deck memory
// (two mirrored copies for two read ports) and the copy scratch memory, and
// drives the result register.
// ----------------------------------------------------------------------------
module cdse_back #(
  parameter int DECK_SIZE = cdse_pkg::DECK_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  cdse_pkg::cmd_t                cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cdse_pkg::CARD_W-1:0]   card_value,
  output logic                          last_card
);
  import cdse_pkg::*;

  localparam int AW    = $clog2(DECK_SIZE);
  localparam int DIV_W = $clog2(DECK_SIZE + 1);
  localparam int SUM_W = $clog2(DECK_SIZE + STRIDE_MAX + 1);
  localparam logic [AW-1:0] LAST = AW'(DECK_SIZE - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_SWW1 = 3'd2;
  localparam logic [2:0] S_SWW2 = 3'd3;
  localparam logic [2:0] S_COPY = 3'd4;
  localparam logic [2:0] S_DEAL = 3'd5;
  localparam logic [2:0] S_READ = 3'd6;

  logic [2:0]          state;
  logic [AW-1:0]       swap_counter;
  logic [DECK_SIZE-1:0] valid;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       j;
  logic [AW-1:0]       cls;
  logic [STRIDE_W-1:0] cur_stride;
  logic                cur_reverse;
  logic [AW-1:0]       swap_r;
  logic [CARD_W-1:0]   swap_hold;
  logic                copy_pend;
  logic [AW-1:0]       copy_idx;
  logic                deal_pend;
  logic [AW-1:0]       deal_pos;
  logic                rd_inflight;
  logic                rd_last;
  logic [AW-1:0]       raddr_a_q;
  logic [AW-1:0]       raddr_b_q;
  logic                rvld_a_q;
  logic                rvld_b_q;

  logic [AW-1:0]       hi;
  logic [AW-1:0]       raddr_a;
  logic [AW-1:0]       raddr_b;
  logic [CARD_W-1:0]   rdata_a;
  logic [CARD_W-1:0]   rdata_b;
  logic [CARD_W-1:0]   val_a;
  logic [CARD_W-1:0]   val_b;
  logic                deck_we;
  logic [AW-1:0]       deck_waddr;
  logic [CARD_W-1:0]   deck_wdata;
  logic [CARD_W-1:0]   copy_rdata;
  logic                read_issue;
  logic                dispatch;
  logic                mod_start;
  logic                mod_done;
  logic [DIV_W-1:0]    mod_rem;
  logic [DIV_W-1:0]    divisor;
  logic [SUM_W-1:0]    next_j;

  // Swap positions and divisor derived from the step counter.
  assign hi      = LAST - swap_counter;
  assign divisor = DIV_W'(DECK_SIZE) - DIV_W'(swap_counter);
  assign next_j  = SUM_W'(j) + SUM_W'(cur_stride);

  // Entries never written since the last init read as their own index.
  assign val_a = rvld_a_q ? rdata_a : CARD_W'(raddr_a_q);
  assign val_b = rvld_b_q ? rdata_b : CARD_W'(raddr_b_q);

  // Command dispatch only with no write or readout left in flight.
  assign cmd_ready  = (state == S_IDLE) && !deal_pend && !copy_pend && !rd_inflight;
  assign dispatch   = cmd_valid && cmd_ready;
  assign mod_start  = dispatch && (cmd.req == REQ_SWAP);
  assign read_issue = (state == S_READ) && !rd_inflight && (!out_valid || out_ready);

  // Read address selection for both deck ports.
  always_comb begin
    raddr_a = idx;
    raddr_b = swap_r;
    case (state)
      S_MOD: begin
        raddr_a = hi;
        raddr_b = AW'(mod_rem);
      end
      S_COPY: begin
        raddr_a = cur_reverse ? (LAST - idx) : idx;
      end
      default: begin
        raddr_a = idx;
      end
    endcase
  end

  // Deck write selection: swap writes, then dealt cards.
  always_comb begin
    deck_we    = 1'b0;
    deck_waddr = deal_pos;
    deck_wdata = copy_rdata;
    case (state)
      S_SWW1: begin
        deck_we    = 1'b1;
        deck_waddr = hi;
        deck_wdata = val_b;
      end
      S_SWW2: begin
        deck_we    = 1'b1;
        deck_waddr = swap_r;
        deck_wdata = swap_hold;
      end
      default: begin
        deck_we = deal_pend;
      end
    endcase
  end

  // Remainder unit for the swap draw.
  cdse_mod #(
    .DIV_W (DIV_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (cmd.rand_value),
    .divisor  (divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Deck memory, mirrored so that both swap entries read in the same cycle.
  cdse_ram #(
    .WIDTH (CARD_W),
    .DEPTH (DECK_SIZE)
  ) u_deck_a (
    .clk   (clk),
    .we    (deck_we),
    .waddr (deck_waddr),
    .wdata (deck_wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  cdse_ram #(
    .WIDTH (CARD_W),
    .DEPTH (DECK_SIZE)
  ) u_deck_b (
    .clk   (clk),
    .we    (deck_we),
    .waddr (deck_waddr),
    .wdata (deck_wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Scratch copy of the deck for the stride pass.
  cdse_ram #(
    .WIDTH (CARD_W),
    .DEPTH (DECK_SIZE)
  ) u_copy (
    .clk   (clk),
    .we    (copy_pend),
    .waddr (copy_idx),
    .wdata (val_a),
    .raddr (j),
    .rdata (copy_rdata)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      swap_counter <= '0;
      valid        <= '0;
      idx          <= '0;
      j            <= '0;
      cls          <= '0;
      copy_pend    <= 1'b0;
      deal_pend    <= 1'b0;
      rd_inflight  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      copy_pend   <= 1'b0;
      deal_pend   <= 1'b0;
      rd_inflight <= read_issue;

      if (deck_we) begin
        valid[deck_waddr] <= 1'b1;
      end

      // Result register: loaded by a returning read, emptied by a transaction.
      if (rd_inflight) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (dispatch) begin
            case (cmd.req)
              REQ_INIT: begin
                valid        <= '0;
                swap_counter <= '0;
              end
              REQ_SWAP: begin
                state <= S_MOD;
              end
              REQ_STRIDE: begin
                state <= S_COPY;
                idx   <= '0;
              end
              REQ_READ: begin
                state <= S_READ;
                idx   <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_SWW1;
          end
        end
        S_SWW1: begin
          state <= S_SWW2;
        end
        S_SWW2: begin
          swap_counter <= (swap_counter == LAST) ? '0 : swap_counter + 1'b1;
          state        <= S_IDLE;
        end
        S_COPY: begin
          copy_pend <= 1'b1;
          if (idx == LAST) begin
            state <= S_DEAL;
            idx   <= '0;
            j     <= '0;
            cls   <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DEAL: begin
          deal_pend <= 1'b1;
          if (idx == LAST) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
          // Walk the current residue class, then start the next one.
          if (next_j < SUM_W'(DECK_SIZE)) begin
            j <= AW'(next_j);
          end else begin
            cls <= cls + 1'b1;
            j   <= cls + 1'b1;
          end
        end
        S_READ: begin
          if (read_issue) begin
            if (idx == LAST) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    raddr_a_q <= raddr_a;
    raddr_b_q <= raddr_b;
    rvld_a_q  <= valid[raddr_a];
    rvld_b_q  <= valid[raddr_b];
    copy_idx  <= idx;
    deal_pos  <= idx;
    if (dispatch) begin
      cur_stride  <= cmd.stride;
      cur_reverse <= cmd.reverse;
    end
    if ((state == S_MOD) && mod_done) begin
      swap_r <= AW'(mod_rem);
    end
    if (state == S_SWW1) begin
      swap_hold <= val_a;
    end
    if (read_issue) begin
      rd_last <= (idx == LAST);
    end
    if (rd_inflight) begin
      card_value <= val_a;
      last_card  <= rd_last;
    end
  end

  // The step counter never reaches the deck size.
  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    swap_counter < AW'(DECK_SIZE - 1) || swap_counter == LAST)
    else $error("swap counter out of range");

  // A returning readout word always finds the result register free.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    rd_inflight |-> !out_valid)
    else $error("readout data would overwrite a pending result");

  // Copy writes and dealt writes never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(copy_pend && deal_pend))
    else $error("copy and deal writes overlap");

  // The remainder unit finishes only while a swap waits for it.
  a_mod_owner: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("remainder finished outside a swap step");

  // Init leaves every deck entry reading as its identity value.
  a_init_clear: assert property (@(posedge clk) disable iff (rst)
    (dispatch && (cmd.req == REQ_INIT)) |=> (valid == '0) && (swap_counter == '0))
    else $error("init did not restore identity order");

endmodule
